>>> src/tecs_pkg.sv
// shared types and constants for the exact-cost tour search block
// used by tecs_ctrl, tecs_dp and tour_of_exact_cost_search_core; no dependencies
package tecs_pkg;

  // default sizing handed to the top level parameters
  localparam int MAX_NODES_DEF   = 8;
  localparam int WEIGHT_BITS_DEF = 16;

  // fixed field widths of the configuration, request and result items
  localparam int TARGET_BITS       = 20;
  localparam int COUNT_BITS        = 4;
  localparam int NODE_FIELD_BITS   = 3;
  localparam int WEIGHT_FIELD_BITS = 16;
  localparam int CFG_DATA_BITS     = 20;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  // configuration register indexes
  localparam logic CFG_TARGET = 1'b0;
  localparam logic CFG_NODES  = 1'b1;

  localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = 4'd8;

  typedef struct packed {
    logic                                req_type;
    logic [NODE_FIELD_BITS-1:0]          row;
    logic [NODE_FIELD_BITS-1:0]          col;
    logic signed [WEIGHT_FIELD_BITS-1:0] weight;
  } req_t;

  typedef struct packed {
    logic                       found;
    logic [NODE_FIELD_BITS-1:0] node;
    logic                       last;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_wr;
    logic run_start;
    logic init;
    logic next_start;
    logic rd;
    logic push;
    logic skip;
    logic pop;
    logic emit;
    logic emit_none;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_run;
    logic depth_full;
    logic cand_over;
    logic cand_visited;
    logic edge_ok;
    logic cost_match;
    logic depth_zero;
    logic start_last;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

>>> src/tour_of_exact_cost_search_core.sv
// Exact-cost tour search core. A load request stores one weight if its row and column are
// in range. A run request is accepted, then each start node gets a setup step; each search
// step skips a visited candidate, reads an edge (a candidate or the closing edge), finds a
// level exhausted or pops; results then leave at one per cycle while the receiver is ready
// (the clamped node count plus 1 results, or 1 when not found). One request at a time.
// Synchronous reset returns to idle, target 0, 8 nodes; weights undefined until loaded.
module tour_of_exact_cost_search_core #(
  parameter int MAX_NODES   = tecs_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = tecs_pkg::WEIGHT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [tecs_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  tecs_pkg::req_t                     req_data,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output tecs_pkg::rsp_t                     rsp_data
);
  import tecs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // search sequencer
  tecs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and arithmetic
  tecs_dp #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_data  (req_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

>>> src/tecs_dp.sv
// datapath of the tour search: weight memory, path stack, visited mask,
// running cost, configuration registers and result register; uses tecs_pkg
module tecs_dp #(
  parameter int MAX_NODES   = tecs_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = tecs_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [tecs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  tecs_pkg::req_t                      req_data,
  input  tecs_pkg::cmd_t                      cmd,
  output tecs_pkg::stat_t                     stat,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output tecs_pkg::rsp_t                      rsp_data
);
  import tecs_pkg::*;

  localparam int NB    = $clog2(MAX_NODES);
  localparam int CB    = $clog2(MAX_NODES + 1);
  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AB    = $clog2(DEPTH);
  localparam int CW    = (WEIGHT_BITS + NB > TARGET_BITS) ? WEIGHT_BITS + NB : TARGET_BITS;

  // configuration registers
  logic [TARGET_BITS-1:0] target_cost;
  logic [COUNT_BITS-1:0]  node_count;

  // weight memory
  logic [WEIGHT_BITS-1:0] weight_mem [DEPTH];
  logic [WEIGHT_BITS-1:0] rdata;
  logic [AB-1:0]          waddr;
  logic [AB-1:0]          raddr;
  logic [WEIGHT_BITS-1:0] wdata;
  logic [31:0]            wext;
  logic                   wr_en;

  // search state
  logic [NB-1:0]          path_stack [MAX_NODES];
  logic [CB-1:0]          next_cand  [MAX_NODES];
  logic [WEIGHT_BITS-2:0] cost_stack [MAX_NODES];
  logic [MAX_NODES-1:0]   visited;
  logic [CW-1:0]          running;
  logic [NB-1:0]          depth;
  logic [NB-1:0]          start;
  logic [CB-1:0]          emit_idx;

  logic [CB-1:0]  n;
  logic [CB-1:0]  n_less;
  logic [NB-1:0]  rd_idx;
  logic [NB-1:0]  emit_sel;
  logic [NB-1:0]  cur_node;
  logic [CB-1:0]  cand;
  logic [NB-1:0]  dest;
  logic [NB-1:0]  depth_up;
  logic [31:0]    node_ext;
  logic [CW-1:0]  close_sum;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_cost <= '0;
      node_count  <= NODE_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET: target_cost <= cfg_data[TARGET_BITS-1:0];
        CFG_NODES:  node_count  <= cfg_data[COUNT_BITS-1:0];
        default:    target_cost <= target_cost;
      endcase
    end
  end

  // node count clamped to the supported range
  always_comb begin
    if (node_count < COUNT_BITS'(2)) begin
      n = CB'(2);
    end else if (int'(node_count) > MAX_NODES) begin
      n = CB'(MAX_NODES);
    end else begin
      n = CB'(node_count);
    end
  end
  assign n_less = n - CB'(1);

  // load address and weight cut to the stored width
  assign wext  = {16'b0, req_data.weight};
  assign wdata = wext[WEIGHT_BITS-1:0];
  assign waddr = AB'(int'(req_data.row) * MAX_NODES + int'(req_data.col));
  assign wr_en = cmd.load_wr && (int'(req_data.row) < MAX_NODES)
                 && (int'(req_data.col) < MAX_NODES);

  // stack read port shared by search and result output
  assign emit_sel = stat.emit_last ? '0 : emit_idx[NB-1:0];
  assign rd_idx   = cmd.emit ? emit_sel : depth;
  assign cur_node = path_stack[rd_idx];
  assign cand     = next_cand[depth];
  assign dest     = stat.depth_full ? start : cand[NB-1:0];
  assign raddr    = AB'(int'(cur_node) * MAX_NODES + int'(dest));
  assign depth_up = depth + NB'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      weight_mem[waddr] <= wdata;
    end
    rdata <= weight_mem[raddr];
  end

  // status toward the controller
  assign close_sum         = running + CW'(rdata[WEIGHT_BITS-2:0]);
  assign stat.is_run       = (req_data.req_type == REQ_RUN);
  assign stat.depth_full   = (CB'(depth) == n_less);
  assign stat.cand_over    = (cand >= n);
  assign stat.cand_visited = visited[cand[NB-1:0]];
  assign stat.edge_ok      = !rdata[WEIGHT_BITS-1];
  assign stat.cost_match   = (close_sum == CW'(target_cost));
  assign stat.depth_zero   = (depth == '0);
  assign stat.start_last   = (CB'(start) == n_less);
  assign stat.emit_last    = (emit_idx == n);
  assign stat.out_free     = !rsp_valid || rsp_ready;

  // stack entries, written at init, on a skip and on a push; a pop writes none
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      path_stack[0] <= start;
      next_cand[0]  <= '0;
    end
    if (cmd.skip) begin
      next_cand[depth] <= cand + CB'(1);
    end
    if (cmd.push) begin
      next_cand[depth]     <= cand + CB'(1);
      path_stack[depth_up] <= cand[NB-1:0];
      next_cand[depth_up]  <= '0;
      cost_stack[depth_up] <= rdata[WEIGHT_BITS-2:0];
    end
  end

  // depth, visited mask, running cost and start node
  always_ff @(posedge clk) begin
    if (rst) begin
      visited  <= '0;
      running  <= '0;
      depth    <= '0;
      start    <= '0;
      emit_idx <= '0;
    end else begin
      if (cmd.run_start) begin
        start <= '0;
      end
      if (cmd.next_start) begin
        start <= start + NB'(1);
      end
      if (cmd.init) begin
        depth    <= '0;
        visited  <= MAX_NODES'(1) << start;
        running  <= '0;
        emit_idx <= '0;
      end
      if (cmd.push) begin
        depth   <= depth_up;
        visited <= visited | (MAX_NODES'(1) << cand[NB-1:0]);
        running <= close_sum;
      end
      if (cmd.pop) begin
        depth   <= depth - NB'(1);
        visited <= visited & ~(MAX_NODES'(1) << cur_node);
        running <= running - CW'(cost_stack[depth]);
      end
      if (cmd.emit) begin
        emit_idx <= emit_idx + CB'(1);
      end
    end
  end

  // result register
  assign node_ext = 32'(cur_node);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_none) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_data.found <= 1'b1;
      rsp_data.node  <= node_ext[NODE_FIELD_BITS-1:0];
      rsp_data.last  <= stat.emit_last;
    end else if (cmd.emit_none) begin
      rsp_data.found <= 1'b0;
      rsp_data.node  <= '0;
      rsp_data.last  <= 1'b1;
    end
  end

  // every edge read happens on a path of depth+1 distinct nodes
  a_visited_count: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> ($countones(visited) == int'(depth) + 1))
    else $error("visited mask out of step with path depth");

  // a push only follows an existing edge below the full depth
  a_push_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!stat.depth_full && stat.edge_ok))
    else $error("push at full depth or over a missing edge");

  // a result is never written over one not yet taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_none) |-> stat.out_free)
    else $error("result register overwritten");

endmodule

>>> src/tecs_ctrl.sv
// controller state machine of the tour search: sequences loads, the
// depth-first search and the result output; uses tecs_pkg
module tecs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  tecs_pkg::stat_t stat,
  output tecs_pkg::cmd_t  cmd
);
  import tecs_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_INIT  = 7'b0000010,
    ST_CHECK = 7'b0000100,
    ST_EVAL  = 7'b0001000,
    ST_POP   = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_NONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (stat.is_run) begin
            cmd.run_start = 1'b1;
            state_next    = ST_INIT;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.depth_full) begin
          cmd.rd     = 1'b1;
          state_next = ST_EVAL;
        end else if (stat.cand_over) begin
          state_next = ST_POP;
        end else if (stat.cand_visited) begin
          cmd.skip = 1'b1;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat.depth_full) begin
          if (stat.edge_ok && stat.cost_match) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_POP;
          end
        end else if (stat.edge_ok) begin
          cmd.push   = 1'b1;
          state_next = ST_CHECK;
        end else begin
          cmd.skip   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_POP: begin
        if (!stat.depth_zero) begin
          cmd.pop    = 1'b1;
          state_next = ST_CHECK;
        end else if (stat.start_last) begin
          state_next = ST_NONE;
        end else begin
          cmd.next_start = 1'b1;
          state_next     = ST_INIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_NONE: begin
        if (stat.out_free) begin
          cmd.emit_none = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // commands never overlap
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one command issued");

  // the closing result of a tour returns the block to accepting requests
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && stat.emit_last) |=> req_ready)
    else $error("not idle after last result");

endmodule
